/* rtl/core/ppu_pkg.sv */
// Shared types and constants of the particle pool update block.
// No dependencies; compile first.
package ppu_pkg;

    localparam int SLOTS   = 64;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int COUNT_W = $clog2(SLOTS + 1);

    // divider sizing: 16 quotient bits, dividend below divisor * 2^16
    localparam int DIVD_W = 54;
    localparam int DIVS_W = 36;
    localparam int QUO_W  = 16;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_SPAWN = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] elapsed;
        logic [5:0]  slot;
        logic [47:0] start_position;
        logic [47:0] start_velocity;
        logic [31:0] spin;
        logic [15:0] scale_begin;
        logic [15:0] scale_final;
        logic [12:0] alpha_begin;
        logic [12:0] alpha_final;
        logic [15:0] life_span;
        logic [7:0]  style;
    } cmd_item_t;

    typedef struct packed {
        logic        accepted;
        logic [6:0]  live_count;
        logic        slot_active;
        logic [47:0] position;
        logic [15:0] angle;
        logic [15:0] size;
        logic [12:0] opacity;
        logic [7:0]  kind;
    } rsp_item_t;

    // one slot as stored in the slot memory
    typedef struct packed {
        logic [2:0][15:0] pos;
        logic [2:0][15:0] vel;
        logic [15:0]      angle;
        logic [15:0]      rate;
        logic [15:0]      sc_begin;
        logic [15:0]      sc_final;
        logic [15:0]      sc_now;
        logic [12:0]      al_begin;
        logic [12:0]      al_final;
        logic [12:0]      al_now;
        logic [15:0]      age;
        logic [15:0]      life;
        logic [7:0]       kind;
    } slot_rec_t;

    localparam int REC_W = $bits(slot_rec_t);

endpackage

/* rtl/core/ppu_cmd_if.sv */
// Command channel of the particle pool update block: valid, ready, payload.
// Depends on ppu_pkg.
interface ppu_cmd_if;
    import ppu_pkg::*;

    logic      valid;
    logic      ready;
    cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/ppu_rsp_if.sv */
// Response channel of the particle pool update block: valid, ready, payload.
// Depends on ppu_pkg.
interface ppu_rsp_if;
    import ppu_pkg::*;

    logic      valid;
    logic      ready;
    rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/ppu_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ppu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/ppu_div.sv */
// Restoring divider, one quotient bit per cycle, 16 quotient bits.
// Depends on ppu_pkg; the dividend must be below divisor * 2^16.
module ppu_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ppu_pkg::DIVD_W-1:0]  dividend,
    input  logic [ppu_pkg::DIVS_W-1:0]  divisor,
    output logic                        done,
    output logic [ppu_pkg::QUO_W-1:0]   quotient
);
    import ppu_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic [DIVD_W-1:0] rem_reg;
    logic [DIVD_W-1:0] dsh_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              fits;

    assign fits     = rem_reg >= dsh_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= dividend;
                dsh_reg  <= DIVD_W'(divisor) << (QUO_W - 1);
                cnt_reg  <= CNT_W'(QUO_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (fits)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                quo_reg <= {quo_reg[QUO_W-2:0], fits};
                dsh_reg <= dsh_reg >> 1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/core/particle_pool_update.sv */
// Particle pool update: top level with slot sequencer, slot memory and dividers.
// Depends on ppu_pkg, ppu_cmd_if, ppu_rsp_if, ppu_ram, ppu_div.
//
// A pool of 64 particle slots held in one slot memory with registered read
// data, with live flags in flip-flops. Every command gives exactly one
// response. A spawn scans the live flags from slot 0 for the first free
// slot. A tick walks every slot: a free slot is skipped, a slot that expires
// has its live flag cleared, and a slot that is updated passes through the
// motion steps and the two bit-serial dividers that form the scale and
// alpha weights. The response moves into the output register once that
// register is free; the next command is taken while that response waits.
module particle_pool_update (
    input  logic       clk,
    input  logic       rst_n,
    ppu_cmd_if.sink    cmd,
    ppu_rsp_if.source  rsp
);
    import ppu_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPAWN_SCAN,
        ST_READ_WAIT,
        ST_TICK_SCAN,
        ST_TICK_LOAD,
        ST_TICK_M1,
        ST_TICK_M2,
        ST_TICK_M3,
        ST_TICK_DSTART,
        ST_TICK_DIV,
        ST_TICK_M4,
        ST_TICK_WR,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [SLOTS-1:0]    live_reg;
    logic [COUNT_W-1:0]  total_reg;
    cmd_item_t           item_reg;
    rsp_item_t           res_reg;
    rsp_item_t           res_clear;
    rsp_item_t           out_data_reg;
    rsp_item_t           out_data_next;
    logic                out_valid_reg;
    slot_rec_t           rec_reg;
    logic [15:0]         a_reg;

    logic signed [32:0]  pd_reg  [3];
    logic signed [29:0]  vd_reg  [3];
    logic signed [32:0]  prr_reg;
    logic [31:0]         l2_reg;
    logic [37:0]         num_reg;
    logic [35:0]         d2_reg;
    logic signed [33:0]  ms_reg;
    logic signed [30:0]  ma_reg;

    // slot memory
    logic                ram_we;
    logic [IDX_W-1:0]    ram_raddr;
    logic [REC_W-1:0]    ram_wdata;
    logic [REC_W-1:0]    ram_rdata;
    slot_rec_t           rdat;
    slot_rec_t           spawn_rec;
    slot_rec_t           upd_rec;

    // dividers
    logic                div_start;
    logic [DIVD_W-1:0]   sc_dividend;
    logic [DIVD_W-1:0]   al_dividend;
    logic [DIVS_W-1:0]   sc_divisor;
    logic [DIVS_W-1:0]   l9;
    logic                sc_done;
    logic                al_done;
    logic [QUO_W-1:0]    sc_q;
    logic [QUO_W-1:0]    al_q;

    // arithmetic
    logic [15:0]         dt;
    logic [16:0]         age_sum;
    logic                expired;
    logic [17:0]         dt2;
    logic [17:0]         dt3h;
    logic [12:0]         fh;
    logic [12:0]         fy;
    logic signed [32:0]  pd_c    [3];
    logic signed [29:0]  vd_c    [3];
    logic signed [32:0]  prr_c;
    logic [15:0]         pos_new [3];
    logic [15:0]         vel_new [3];
    logic signed [32:0]  ang_del;
    logic [18:0]         a7;
    logic [20:0]         e21;
    logic                br1;
    logic                bra;
    logic [18:0]         d19;
    logic [18:0]         lin;
    logic signed [16:0]  sdiff;
    logic signed [13:0]  adiff;
    logic signed [33:0]  ms_c;
    logic signed [30:0]  ma_c;
    logic signed [33:0]  srnd;
    logic signed [30:0]  arnd;
    logic                last_slot;
    logic                out_free;
    logic                read_ok;

    function automatic logic [15:0] sat16(input logic signed [33:0] v);
        if (v > 34'sd32767)
        begin
            return 16'h7FFF;
        end
        if (v < -34'sd32768)
        begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    ppu_ram #(
        .WIDTH (REC_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ppu_div u_div_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sc_dividend),
        .divisor  (sc_divisor),
        .done     (sc_done),
        .quotient (sc_q)
    );

    ppu_div u_div_alpha (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (al_dividend),
        .divisor  (l9),
        .done     (al_done),
        .quotient (al_q)
    );

    assign cmd.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    assign rdat      = slot_rec_t'(ram_rdata);
    assign dt        = item_reg.elapsed;
    assign last_slot = (idx_reg == IDX_W'(SLOTS - 1));
    assign out_free  = !out_valid_reg || rsp.ready;
    assign read_ok   = (COUNT_W'(item_reg.slot) < COUNT_W'(SLOTS))
                       && live_reg[item_reg.slot[IDX_W-1:0]];
    assign ram_raddr = (state_reg == ST_IDLE) ? cmd.data.slot[IDX_W-1:0] : idx_reg;

    always_comb
    begin
        res_clear                = '0;
        res_clear.accepted       = 1'b1;
        out_data_next            = res_reg;
        out_data_next.live_count = 7'(total_reg);
    end

    always_comb
    begin
        spawn_rec          = '0;
        spawn_rec.pos      = item_reg.start_position;
        spawn_rec.vel      = item_reg.start_velocity;
        spawn_rec.angle    = item_reg.spin[15:0];
        spawn_rec.rate     = item_reg.spin[31:16];
        spawn_rec.sc_begin = item_reg.scale_begin;
        spawn_rec.sc_final = item_reg.scale_final;
        spawn_rec.sc_now   = item_reg.scale_begin;
        spawn_rec.al_begin = item_reg.alpha_begin;
        spawn_rec.al_final = item_reg.alpha_final;
        spawn_rec.al_now   = item_reg.alpha_begin;
        spawn_rec.age      = '0;
        spawn_rec.life     = item_reg.life_span;
        spawn_rec.kind     = item_reg.style;
    end

    // age and damping factors
    assign age_sum = {1'b0, rdat.age} + {1'b0, dt};
    assign expired = age_sum >= {1'b0, rdat.life};
    assign dt2     = {1'b0, dt, 1'b0};
    assign dt3h    = (18'(dt) * 18'd3 + 18'd1) >> 1;
    assign fh      = (dt2 >= 18'd4096) ? '0 : 13'(18'd4096 - dt2);
    assign fy      = (dt3h >= 18'd4096) ? '0 : 13'(18'd4096 - dt3h);

    // motion terms
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pd_c[k]    = $signed(rec_reg.vel[k]) * $signed({1'b0, dt});
            vd_c[k]    = $signed(rec_reg.vel[k])
                         * $signed({1'b0, ((k == 1) ? fy : fh)});
            pos_new[k] = sat16($signed(rec_reg.pos[k])
                               + ((pd_reg[k] + 33'sd2048) >>> 12));
            vel_new[k] = 16'((vd_reg[k] + 30'sd2048) >>> 12);
        end
    end

    assign prr_c   = $signed(rec_reg.rate) * $signed({1'b0, dt});
    assign ang_del = (prr_reg + 33'sd2048) >>> 12;

    // curve terms, a = age after the step, L = life
    assign a7  = 19'(a_reg) * 19'd7;
    assign e21 = 21'(rec_reg.life) * 21'd6 - 21'(a_reg) * 21'd10;
    assign br1 = (20'(a_reg) * 20'd10) < (20'(rec_reg.life) * 20'd3);
    assign bra = (19'(a_reg) * 19'd5) >= (19'(rec_reg.life) * 19'd2);
    assign d19 = 19'(a_reg) * 19'd5 - 19'(rec_reg.life) * 19'd2;
    assign lin = 19'(rec_reg.life) * 19'd4 + 19'(a_reg) * 19'd3;
    assign l9  = 36'({l2_reg, 3'b000}) + 36'(l2_reg);

    assign div_start   = (state_reg == ST_TICK_DSTART);
    assign sc_dividend = br1 ? DIVD_W'({num_reg, 16'h0000}) : DIVD_W'({lin, 16'h0000});
    assign sc_divisor  = br1 ? l9 : DIVS_W'(19'(rec_reg.life) * 19'd7);
    assign al_dividend = bra ? DIVD_W'({d2_reg, 16'h0000}) : '0;

    assign sdiff = $signed({1'b0, rec_reg.sc_final}) - $signed({1'b0, rec_reg.sc_begin});
    assign adiff = $signed({1'b0, rec_reg.al_final}) - $signed({1'b0, rec_reg.al_begin});
    assign ms_c  = sdiff * $signed({1'b0, sc_q});
    assign ma_c  = adiff * $signed({1'b0, al_q});
    assign srnd  = (ms_reg + 34'sd32768) >>> 16;
    assign arnd  = (ma_reg + 31'sd32768) >>> 16;

    always_comb
    begin
        upd_rec        = rec_reg;
        upd_rec.age    = a_reg;
        upd_rec.sc_now = rec_reg.sc_begin + srnd[15:0];
        upd_rec.al_now = bra ? (rec_reg.al_begin + arnd[12:0]) : rec_reg.al_begin;
    end

    assign ram_we    = ((state_reg == ST_SPAWN_SCAN) && !live_reg[idx_reg])
                       || (state_reg == ST_TICK_WR);
    assign ram_wdata = (state_reg == ST_TICK_WR) ? REC_W'(upd_rec) : REC_W'(spawn_rec);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            live_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        item_reg <= cmd.data;
                        res_reg  <= res_clear;
                        idx_reg  <= '0;
                        case (cmd.data.action)
                            ACT_TICK:  state_reg <= ST_TICK_SCAN;
                            ACT_SPAWN: state_reg <= ST_SPAWN_SCAN;
                            ACT_READ:  state_reg <= ST_READ_WAIT;
                            ACT_CLEAR:
                            begin
                                live_reg  <= '0;
                                total_reg <= '0;
                                state_reg <= ST_FINISH;
                            end
                            default:   state_reg <= ST_FINISH;
                        endcase
                    end
                end

                ST_SPAWN_SCAN:
                begin
                    if (!live_reg[idx_reg])
                    begin
                        live_reg[idx_reg] <= 1'b1;
                        total_reg         <= total_reg + 1'b1;
                        state_reg         <= ST_FINISH;
                    end
                    else if (last_slot)
                    begin
                        res_reg.accepted <= 1'b0;
                        state_reg        <= ST_FINISH;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end

                ST_READ_WAIT:
                begin
                    if (read_ok)
                    begin
                        res_reg.slot_active <= 1'b1;
                        res_reg.position    <= rdat.pos;
                        res_reg.angle       <= rdat.angle;
                        res_reg.size        <= rdat.sc_now;
                        res_reg.opacity     <= rdat.al_now;
                        res_reg.kind        <= rdat.kind;
                    end
                    state_reg <= ST_FINISH;
                end

                ST_TICK_SCAN:
                begin
                    if (live_reg[idx_reg])
                    begin
                        state_reg <= ST_TICK_LOAD;
                    end
                    else if (last_slot)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end

                ST_TICK_LOAD:
                begin
                    rec_reg <= rdat;
                    a_reg   <= age_sum[15:0];
                    if (expired)
                    begin
                        live_reg[idx_reg] <= 1'b0;
                        total_reg         <= total_reg - 1'b1;
                        if (last_slot)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_TICK_SCAN;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_TICK_M1;
                    end
                end

                ST_TICK_M1:
                begin
                    pd_reg    <= pd_c;
                    prr_reg   <= prr_c;
                    state_reg <= ST_TICK_M2;
                end

                ST_TICK_M2:
                begin
                    vd_reg        <= vd_c;
                    rec_reg.pos   <= {pos_new[2], pos_new[1], pos_new[0]};
                    rec_reg.angle <= rec_reg.angle + ang_del[15:0];
                    state_reg     <= ST_TICK_M3;
                end

                ST_TICK_M3:
                begin
                    rec_reg.vel <= {vel_new[2], vel_new[1], vel_new[0]};
                    l2_reg      <= 32'(rec_reg.life) * 32'(rec_reg.life);
                    num_reg     <= 38'(a7) * 38'(e21[18:0]);
                    d2_reg      <= 36'(d19[17:0]) * 36'(d19[17:0]);
                    state_reg   <= ST_TICK_DSTART;
                end

                ST_TICK_DSTART:
                begin
                    state_reg <= ST_TICK_DIV;
                end

                ST_TICK_DIV:
                begin
                    if (sc_done && al_done)
                    begin
                        state_reg <= ST_TICK_M4;
                    end
                end

                ST_TICK_M4:
                begin
                    ms_reg    <= ms_c;
                    ma_reg    <= ma_c;
                    state_reg <= ST_TICK_WR;
                end

                ST_TICK_WR:
                begin
                    if (last_slot)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_TICK_SCAN;
                    end
                end

                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_data_reg <= out_data_next;
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* tb/sv/ppu_checker.sv */
`timescale 1ns / 100ps
// Transfer monitor and scoreboard of the particle pool update block.
// Depends on ppu_pkg, ppu_cmd_if, ppu_rsp_if.
module ppu_checker (
    input  logic  clk,
    input  logic  rst_n,
    ppu_cmd_if    cmd,
    ppu_rsp_if    rsp,
    output int    errors,
    output int    pending
);
    import ppu_pkg::*;

    logic        live [SLOTS];
    int          pos [SLOTS][3];
    int          vel [SLOTS][3];
    int          ang [SLOTS];
    int          rate [SLOTS];
    int          sc_b [SLOTS], sc_f [SLOTS], sc_n [SLOTS];
    int          al_b [SLOTS], al_f [SLOTS], al_n [SLOTS];
    int          age [SLOTS], life [SLOTS];
    logic [7:0]  kind [SLOTS];
    int          live_total;
    rsp_item_t   expected_rsp [$];

    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic int sat16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return int'(v);
    endfunction

    function automatic void advance_slot(int i, longint dt);
        longint a, l, fh, fy, w, d, f;
        a = longint'(age[i]) + dt;
        l = life[i];
        if (a >= l)
        begin
            live[i] = 1'b0;
            if (live_total > 0)
                live_total--;
            return;
        end
        age[i] = int'(a);
        for (int k = 0; k < 3; k++)
            pos[i][k] = sat16(pos[i][k] + rnd_shift(vel[i][k] * dt, 12));
        fh = 4096 - 2 * dt;
        fy = 4096 - ((3 * dt + 1) >>> 1);
        if (fh < 0)
            fh = 0;
        if (fy < 0)
            fy = 0;
        vel[i][0] = int'(rnd_shift(vel[i][0] * fh, 12));
        vel[i][1] = int'(rnd_shift(vel[i][1] * fy, 12));
        vel[i][2] = int'(rnd_shift(vel[i][2] * fh, 12));
        ang[i] = int'((ang[i] + rnd_shift(rate[i] * dt, 12)) & 64'hFFFF);
        if (10 * a < 3 * l)
            w = ((7 * a * (6 * l - 10 * a)) <<< 16) / (9 * l * l);
        else
            w = ((4 * l + 3 * a) <<< 16) / (7 * l);
        sc_n[i] = int'(sc_b[i] + rnd_shift((longint'(sc_f[i]) - sc_b[i]) * w, 16));
        if (5 * a < 2 * l)
            al_n[i] = al_b[i];
        else
        begin
            d = 5 * a - 2 * l;
            f = ((d * d) <<< 16) / (9 * l * l);
            al_n[i] = int'(al_b[i] + rnd_shift((longint'(al_f[i]) - al_b[i]) * f, 16));
        end
    endfunction

    function automatic rsp_item_t apply_command(cmd_item_t c);
        rsp_item_t r;
        int        n;
        r = '0;
        r.accepted = 1'b1;
        case (action_t'(c.action))
            ACT_TICK:
                for (int i = 0; i < SLOTS; i++)
                    if (live[i])
                        advance_slot(i, longint'(c.elapsed));
            ACT_SPAWN:
            begin
                n = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (!live[i] && n < 0)
                        n = i;
                if (n < 0)
                    r.accepted = 1'b0;
                else
                begin
                    live[n] = 1'b1;
                    for (int k = 0; k < 3; k++)
                    begin
                        pos[n][k] = int'($signed(c.start_position[16*k +: 16]));
                        vel[n][k] = int'($signed(c.start_velocity[16*k +: 16]));
                    end
                    ang[n]  = int'(c.spin[15:0]);
                    rate[n] = int'($signed(c.spin[31:16]));
                    sc_b[n] = int'(c.scale_begin);
                    sc_f[n] = int'(c.scale_final);
                    sc_n[n] = sc_b[n];
                    al_b[n] = int'(c.alpha_begin);
                    al_f[n] = int'(c.alpha_final);
                    al_n[n] = al_b[n];
                    life[n] = int'(c.life_span);
                    age[n]  = 0;
                    kind[n] = c.style;
                    live_total++;
                end
            end
            ACT_READ:
                if (live[c.slot])
                begin
                    r.slot_active = 1'b1;
                    for (int k = 0; k < 3; k++)
                        r.position[16*k +: 16] = pos[c.slot][k][15:0];
                    r.angle   = ang[c.slot][15:0];
                    r.size    = sc_n[c.slot][15:0];
                    r.opacity = al_n[c.slot][12:0];
                    r.kind    = kind[c.slot];
                end
            default:
            begin
                foreach (live[i])
                    live[i] = 1'b0;
                live_total = 0;
            end
        endcase
        r.live_count = live_total[6:0];
        return r;
    endfunction

    function automatic int field_diff(string name, longint e, longint a);
        if (e == a)
            return 0;
        if (errors < 10)
            $display("mismatch %0s: expected %0h, got %0h", name, e, a);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_item_t e, a;
        int        bad;
        if (!rst_n)
        begin
            foreach (live[i])
                live[i] = 1'b0;
            live_total = 0;
            errors = 0;
            expected_rsp.delete();
            pending = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                a = rsp.data;
                if (expected_rsp.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected response transfer %0h", a);
                    errors++;
                end
                else
                begin
                    e = expected_rsp.pop_front();
                    bad = 0;
                    bad += field_diff("accepted", e.accepted, a.accepted);
                    bad += field_diff("live_count", e.live_count, a.live_count);
                    bad += field_diff("slot_active", e.slot_active, a.slot_active);
                    bad += field_diff("position", e.position, a.position);
                    bad += field_diff("angle", e.angle, a.angle);
                    bad += field_diff("size", e.size, a.size);
                    bad += field_diff("opacity", e.opacity, a.opacity);
                    bad += field_diff("kind", e.kind, a.kind);
                    if (bad != 0)
                        errors++;
                end
            end
            if (cmd.valid && cmd.ready)
                expected_rsp.push_back(apply_command(cmd.data));
            pending = expected_rsp.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Top of the particle pool update testbench: clock, reset, stimulus, verdict.
// Depends on ppu_pkg, both channel interfaces, ppu_checker and the block.
module testbench;
    import ppu_pkg::*;

    localparam int ITEMS      = 1170;
    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   errors, pending;
    int   idle_cycles = 0;
    int   cycle_no = 0;
    int   n_sent, n_tick, n_spawn, n_read, n_clear;

    ppu_cmd_if cmd ();
    ppu_rsp_if rsp ();

    particle_pool_update i_dut (.clk(clk), .rst_n(rst_n), .cmd(cmd), .rsp(rsp));
    ppu_checker i_chk (.clk(clk), .rst_n(rst_n), .cmd(cmd), .rsp(rsp),
                       .errors(errors), .pending(pending));

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // response side: random stalls, plus two long hold-offs
    initial
    begin
        int stall;
        stall = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (cycle_no == 3000 || cycle_no == 150000)
                stall = 4000;
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                stall--;
            end
            else if ($urandom_range(99) < 3)
            begin
                stall = $urandom_range(60, 5);
                rsp.ready <= 1'b0;
            end
            else if ((cycle_no / 500) % 4 == 0)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(99) < 70);
        end
    end

    task automatic send(input cmd_item_t c);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.data  <= c;
        do
            @(posedge clk);
        while (!cmd.ready);
        n_sent++;
        case (action_t'(c.action))
            ACT_TICK:  n_tick++;
            ACT_SPAWN: n_spawn++;
            ACT_READ:  n_read++;
            default:   n_clear++;
        endcase
    endtask

    function automatic cmd_item_t any_item();
        cmd_item_t c;
        c.action         = 2'($urandom_range(3));
        c.elapsed        = 16'($urandom);
        c.slot           = 6'($urandom);
        c.start_position = 48'({$urandom, $urandom});
        c.start_velocity = 48'({$urandom, $urandom});
        c.spin           = $urandom;
        c.scale_begin    = 16'($urandom);
        c.scale_final    = 16'($urandom);
        c.alpha_begin    = 13'(($urandom_range(9) == 0) ? $urandom : $urandom_range(4096));
        c.alpha_final    = 13'(($urandom_range(9) == 0) ? $urandom : $urandom_range(4096));
        c.life_span      = 16'($urandom);
        c.style          = 8'($urandom);
        return c;
    endfunction

    function automatic cmd_item_t op_item(action_t act, int dt, int idx, int life_q);
        cmd_item_t c;
        c           = any_item();
        c.action    = act;
        c.elapsed   = 16'(dt);
        c.slot      = 6'(idx);
        c.life_span = 16'(life_q);
        return c;
    endfunction

    initial
    begin
        cmd_item_t c;
        int        burst, steps;
        rst_n       = 1'b0;
        cmd.valid   = 1'b0;
        cmd.data    = '0;
        n_sent = 0; n_tick = 0; n_spawn = 0; n_read = 0; n_clear = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        send(op_item(ACT_READ, 0, 0, 0));
        send(op_item(ACT_READ, 0, 63, 0));
        c = '1;
        c.action = ACT_SPAWN;
        send(c);
        c = '0;
        c.action = ACT_SPAWN;
        send(c);
        c = op_item(ACT_SPAWN, 0, 0, 16'h8000);
        c.alpha_begin = 13'd4096;
        c.alpha_final = 13'd0;
        c.start_velocity = {16'h8000, 16'h8000, 16'h8000};
        c.spin = {16'h8000, 16'hFFFF};
        send(c);
        send(op_item(ACT_READ, 0, 0, 0));
        send(op_item(ACT_READ, 0, 1, 0));
        send(op_item(ACT_READ, 0, 2, 0));
        send(op_item(ACT_TICK, 0, 0, 0));
        send(op_item(ACT_READ, 0, 1, 0));
        send(op_item(ACT_TICK, 16'h4000, 0, 0));
        send(op_item(ACT_READ, 0, 2, 0));
        send(op_item(ACT_TICK, 16'hFFFF, 0, 0));
        send(op_item(ACT_READ, 0, 0, 0));
        send(op_item(ACT_SPAWN, 0, 0, 16'hFFFF));
        send(op_item(ACT_TICK, 1, 0, 0));
        send(op_item(ACT_READ, 0, 0, 0));
        send(op_item(ACT_CLEAR, 0, 0, 0));
        send(op_item(ACT_READ, 0, 0, 0));

        // random part: spawn bursts, short ticks and reads, some noise
        while (n_sent < ITEMS)
        begin
            if ($urandom_range(99) < 25)
                send(any_item());
            else
            begin
                if ($urandom_range(9) == 0)
                    send(op_item(ACT_CLEAR, 0, 0, 0));
                burst = ($urandom_range(9) == 0) ? $urandom_range(70, 40)
                                                 : $urandom_range(6, 1);
                repeat (burst)
                    send(op_item(ACT_SPAWN, 0, 0,
                                 ($urandom_range(9) == 0) ? $urandom_range(500)
                                                          : $urandom_range(65535, 2000)));
                steps = $urandom_range(8, 2);
                repeat (steps)
                begin
                    if ($urandom_range(3) == 0)
                        send(op_item(ACT_TICK,
                                     ($urandom_range(19) == 0) ? $urandom_range(65535)
                                                               : $urandom_range(600), 0, 0));
                    else
                        send(op_item(ACT_READ, 0,
                                     ($urandom_range(3) == 0) ? $urandom_range(63)
                                                              : $urandom_range(burst), 0));
                end
            end
        end
        cmd.valid <= 1'b0;

        wait (pending == 0);
        repeat (100) @(posedge clk);
        $display("covered %0d transfers: %0d ticks, %0d spawns, %0d reads, %0d clears",
                 n_sent, n_tick, n_spawn, n_read, n_clear);
        $display("response mismatches: %0d", errors);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/ppu_pkg.sv
rtl/core/ppu_cmd_if.sv
rtl/core/ppu_rsp_if.sv
rtl/core/ppu_ram.sv
rtl/core/ppu_div.sv
rtl/core/particle_pool_update.sv
tb/sv/ppu_checker.sv
tb/sv/testbench.sv
